// ===== hw/rtl/pva_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pva_pkg;

  localparam int unsigned SND_W   = 7;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned SLOT_W  = PRIO_W + 1;   // loaded bit over priority
  localparam int unsigned STAMP_W = 32;

  // level mapping: x*400/127 and x*400/63 through rounded-up reciprocals
  localparam int unsigned VOL_SHIFT = 25;
  localparam int unsigned PAN_SHIFT = 24;
  localparam logic [26:0] VOL_MUL   = 27'(400 * ((2**VOL_SHIFT + 126) / 127));
  localparam logic [26:0] PAN_MUL   = 27'(400 * ((2**PAN_SHIFT + 62) / 63));
  localparam logic [9:0]  VOL_FULL  = 10'd635;
  localparam logic [9:0]  PAN_MID   = 10'd315;

  typedef enum logic [2:0] {
    ACT_PLAY     = 3'd0,
    ACT_STOP     = 3'd1,
    ACT_SET_PRIO = 3'd2,
    ACT_FINISHED = 3'd3,
    ACT_COUNT    = 3'd4,
    ACT_NEWEST   = 3'd5,
    ACT_LOAD     = 3'd6,
    ACT_UNLOAD   = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    PM_FIRST   = 2'd0,
    PM_OLDEST  = 2'd1,
    PM_NEWEST  = 2'd2,
    PM_LOWPRIO = 2'd3
  } pick_mode_t;

  typedef struct packed {
    pick_mode_t mode;
    logic       cand_valid;
    logic       cand_match;
    logic       have;
  } pick_ctl_t;

  typedef struct packed {
    action_t     action;
    logic [6:0]  sound_id;
    logic [7:0]  priority_req;
    logic        allow_restart;
    logic [3:0]  voice_id;
    logic [6:0]  volume_in;
    logic [6:0]  pan_in;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic [3:0]         voice_out;
    logic               replaced;
    logic [3:0]         playing_count;
    logic signed [11:0] volume_atten;
    logic signed [11:0] pan_level;
  } out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pva_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pva_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pva_level_map.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pva_level_map (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [6:0]         volume_in,
  input  wire logic [6:0]         pan_in,
  output logic signed [11:0]      volume_atten,
  output logic signed [11:0]      pan_level
);

  logic [9:0]  vol5;
  logic [9:0]  vx;
  logic [36:0] vprod;
  logic [11:0] vmag;
  logic [9:0]  pan5;
  logic        pan_ge;
  logic [9:0]  pdiff;
  logic [35:0] pprod;
  logic [11:0] pmag;
  logic signed [11:0] volume_atten_r;
  logic signed [11:0] pan_level_r;

  // volume: -(400*(635-5v)/127), v never exceeds 127
  assign vol5  = {1'b0, volume_in, 2'b00} + 10'(volume_in);
  assign vx    = pva_pkg::VOL_FULL - vol5;
  assign vprod = 37'(vx) * 37'(pva_pkg::VOL_MUL);
  assign vmag  = vprod[pva_pkg::VOL_SHIFT+11:pva_pkg::VOL_SHIFT];

  // pan: sign follows 5p against 315, magnitude truncated
  assign pan5   = {1'b0, pan_in, 2'b00} + 10'(pan_in);
  assign pan_ge = pan5 >= pva_pkg::PAN_MID;
  assign pdiff  = pan_ge ? (pan5 - pva_pkg::PAN_MID) : (pva_pkg::PAN_MID - pan5);
  assign pprod  = 36'(pdiff[8:0]) * 36'(pva_pkg::PAN_MUL);
  assign pmag   = pprod[pva_pkg::PAN_SHIFT+11:pva_pkg::PAN_SHIFT];

  always_ff @(posedge clk) begin
    if (en) begin
      volume_atten_r <= $signed(12'd0 - vmag);
      pan_level_r    <= pan_ge ? $signed(pmag) : $signed(12'd0 - pmag);
    end
  end

  assign volume_atten = volume_atten_r;
  assign pan_level    = pan_level_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pva_pick_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pva_pick_unit (
  input  wire pva_pkg::pick_ctl_t                 ctl,
  input  wire logic [pva_pkg::STAMP_W-1:0]        cand_stamp,
  input  wire logic [pva_pkg::STAMP_W-1:0]        best_stamp,
  input  wire logic [pva_pkg::PRIO_W-1:0]         cand_prio,
  input  wire logic [pva_pkg::PRIO_W-1:0]         best_prio,
  output logic                                    take
);

  logic [pva_pkg::STAMP_W-1:0] lhs;
  logic [pva_pkg::STAMP_W-1:0] rhs;
  logic                        lt;

  // one magnitude comparator, operands steered by the pick mode
  always_comb begin
    unique case (ctl.mode)
      pva_pkg::PM_NEWEST: begin
        lhs = best_stamp;
        rhs = cand_stamp;
      end
      pva_pkg::PM_LOWPRIO: begin
        lhs = pva_pkg::STAMP_W'(cand_prio);
        rhs = pva_pkg::STAMP_W'(best_prio);
      end
      pva_pkg::PM_OLDEST,
      pva_pkg::PM_FIRST: begin
        lhs = cand_stamp;
        rhs = best_stamp;
      end
    endcase
  end

  assign lt = lhs < rhs;

  always_comb begin
    unique case (ctl.mode)
      pva_pkg::PM_FIRST:   take = ctl.cand_match && !ctl.have;
      pva_pkg::PM_LOWPRIO: take = ctl.cand_valid && lt;
      pva_pkg::PM_OLDEST,
      pva_pkg::PM_NEWEST:  take = ctl.cand_match && (!ctl.have || lt);
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/priority_voice_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// play into a free or finished voice, priority, finished, load and commands on an
// unloaded sound end in the check state; stop, count, newest and unload end after a
// voice scan; steal ends after the steal pass, steal failing into restart after the
// steal pass and a scan (one voice per cycle through the shared pick comparator, steal
// waits on the slot memory read port); next transaction is taken in the strobe cycle;
// results cannot be stalled; reset: synchronous, then slot memory clearing with busy high
module priority_voice_allocator #(
  parameter int VOICES = 12,
  parameter int SOUNDS = 128
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire pva_pkg::in_t   in_data,
  output logic                out_valid,
  output pva_pkg::out_t       out_data
);

  localparam int VW = $clog2(VOICES);
  localparam int CW = $clog2(VOICES + 1);
  localparam int SW = $clog2(SOUNDS);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_CHK   = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_STEAL = 5'b10000
  } state_t;

  // sequencer state
  state_t state_r, state_nxt;
  logic [SW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] idx_r, idx_nxt;

  // captured transaction
  pva_pkg::in_t req_r;
  logic         range_r;

  // running pick of the voice scan
  logic [VW-1:0]               pick_r, pick_nxt;
  logic                        have_r, have_nxt;
  logic [pva_pkg::STAMP_W-1:0] best_stamp_r, best_stamp_nxt;
  logic [pva_pkg::PRIO_W-1:0]  best_prio_r, best_prio_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;

  // voice table
  logic [VOICES-1:0]           valid_r, valid_nxt;
  logic [VOICES-1:0]           playing_r, playing_nxt;
  logic [pva_pkg::SND_W-1:0]   sound_r [VOICES];
  logic [pva_pkg::STAMP_W-1:0] stamp_r [VOICES];
  logic [CW-1:0]               active_r, active_nxt;
  logic [pva_pkg::STAMP_W-1:0] ctr_r, ctr_nxt;
  logic                        snd_we, stamp_we;
  logic [VW-1:0]               voice_wi;

  // result register
  pva_pkg::out_t out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  // slot memory: loaded bit and priority per sound
  logic                      ram_we;
  logic [SW-1:0]             ram_waddr, ram_raddr;
  logic [pva_pkg::SLOT_W-1:0] ram_wdata, ram_rdata;

  logic                      accept;
  logic [31:0]               in_ext, req_ext, vid_ext, vs_ext;
  logic [SW-1:0]             in_addr, req_addr;
  logic                      in_range, loaded, vid_ok;
  logic [VW-1:0]             vid_vi, vi, ev_vi, rd_vi, take_vi;
  logic [CW-1:0]             ev_idx;
  logic                      match, take, fin_have;
  logic [VW-1:0]             fin_pick;
  logic [VW-1:0]             free_idx, fin_idx;
  logic                      any_fin;
  logic                      cnt_hit;
  pva_pkg::pick_ctl_t        pick_ctl;
  logic signed [11:0]        lvl_vol, lvl_pan;

  // shared actions decided by the sequencer
  logic          do_start, st_repl, do_restart, do_stop, finish;
  logic [VW-1:0] st_pick;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  assign in_ext   = 32'(in_data.sound_id);
  assign in_addr  = in_ext[SW-1:0];
  assign in_range = in_ext < 32'(SOUNDS);
  assign req_ext  = 32'(req_r.sound_id);
  assign req_addr = req_ext[SW-1:0];
  assign loaded   = range_r && ram_rdata[pva_pkg::PRIO_W];

  assign vid_ext = 32'(req_r.voice_id);
  assign vid_ok  = vid_ext < 32'(VOICES);
  assign vid_vi  = vid_ok ? vid_ext[VW-1:0] : '0;

  // scan index, and in the steal pass the voice whose priority is back from memory
  assign vi     = (idx_r < CW'(VOICES)) ? idx_r[VW-1:0] : '0;
  assign rd_vi  = vi;
  assign ev_idx = idx_r - CW'(1);
  assign ev_vi  = ev_idx[VW-1:0];
  assign vs_ext = 32'(sound_r[rd_vi]);
  assign match  = valid_r[vi] && (sound_r[vi] == req_r.sound_id);

  // lowest free voice and lowest finished voice
  always_comb begin
    free_idx = '0;
    fin_idx  = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = VW'(i);
      end
      if (valid_r[i] && !playing_r[i]) begin
        fin_idx = VW'(i);
      end
    end
  end
  assign any_fin = |(valid_r & ~playing_r);

  // pick comparator control
  always_comb begin
    pick_ctl.have       = have_r;
    pick_ctl.cand_match = match;
    pick_ctl.cand_valid = valid_r[vi];
    if (state_r == ST_STEAL) begin
      pick_ctl.mode       = pva_pkg::PM_LOWPRIO;
      pick_ctl.cand_valid = valid_r[ev_vi] && (idx_r != '0);
      pick_ctl.cand_match = 1'b0;
    end else if (state_r != ST_SCAN) begin
      pick_ctl.mode       = pva_pkg::PM_FIRST;
      pick_ctl.cand_match = 1'b0;
    end else if (req_r.action == pva_pkg::ACT_STOP) begin
      pick_ctl.mode = pva_pkg::PM_OLDEST;
    end else if (req_r.action == pva_pkg::ACT_NEWEST) begin
      pick_ctl.mode = pva_pkg::PM_NEWEST;
    end else begin
      pick_ctl.mode = pva_pkg::PM_FIRST;
    end
  end

  pva_pick_unit u_pick (
    .ctl        (pick_ctl),
    .cand_stamp (stamp_r[vi]),
    .best_stamp (best_stamp_r),
    .cand_prio  (ram_rdata[pva_pkg::PRIO_W-1:0]),
    .best_prio  (best_prio_r),
    .take       (take)
  );

  assign take_vi  = (state_r == ST_STEAL) ? ev_vi : vi;
  assign fin_have = have_r || take;
  assign fin_pick = take ? take_vi : pick_r;
  assign cnt_hit  = match && playing_r[vi];

  pva_level_map u_level (
    .clk          (clk),
    .en           (accept),
    .volume_in    (in_data.volume_in),
    .pan_in       (in_data.pan_in),
    .volume_atten (lvl_vol),
    .pan_level    (lvl_pan)
  );

  pva_ram #(
    .WIDTH (pva_pkg::SLOT_W),
    .DEPTH (SOUNDS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    idx_nxt        = idx_r;
    pick_nxt       = pick_r;
    have_nxt       = have_r;
    best_stamp_nxt = best_stamp_r;
    best_prio_nxt  = best_prio_r;
    cnt_nxt        = cnt_r;
    valid_nxt      = valid_r;
    playing_nxt    = playing_r;
    active_nxt     = active_r;
    ctr_nxt        = ctr_r;
    snd_we         = 1'b0;
    stamp_we       = 1'b0;
    voice_wi       = pick_r;
    out_nxt        = '0;
    out_valid_nxt  = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = req_addr;
    ram_wdata      = '0;
    ram_raddr      = req_addr;
    do_start       = 1'b0;
    st_repl        = 1'b0;
    st_pick        = fin_pick;
    do_restart     = 1'b0;
    do_stop        = 1'b0;
    finish         = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        if (clr_r == SW'(SOUNDS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + SW'(1);
        end
      end

      ST_IDLE: begin
        ram_raddr = in_addr;
        if (start) begin
          state_nxt = ST_CHK;
        end
      end

      ST_CHK: begin
        idx_nxt       = '0;
        have_nxt      = 1'b0;
        cnt_nxt       = '0;
        best_prio_nxt = req_r.priority_req;
        unique case (req_r.action)
          pva_pkg::ACT_PLAY: begin
            if (!loaded) begin
              finish = 1'b1;
            end else if (active_r < CW'(VOICES)) begin
              do_start = 1'b1;
              st_pick  = free_idx;
            end else if (any_fin) begin
              // reclaim the lowest finished voice
              do_start = 1'b1;
              st_repl  = 1'b1;
              st_pick  = fin_idx;
            end else begin
              state_nxt = ST_STEAL;
            end
          end
          pva_pkg::ACT_STOP,
          pva_pkg::ACT_COUNT,
          pva_pkg::ACT_NEWEST,
          pva_pkg::ACT_UNLOAD: begin
            if (loaded) begin
              state_nxt = ST_SCAN;
            end else begin
              finish = 1'b1;
            end
          end
          pva_pkg::ACT_SET_PRIO: begin
            finish = 1'b1;
            if (loaded) begin
              ram_we     = 1'b1;
              ram_wdata  = {1'b1, req_r.priority_req};
              out_nxt.ok = 1'b1;
            end
          end
          pva_pkg::ACT_FINISHED: begin
            finish = 1'b1;
            if (vid_ok && valid_r[vid_vi]) begin
              playing_nxt[vid_vi] = 1'b0;
              out_nxt.ok          = 1'b1;
              out_nxt.voice_out   = req_r.voice_id;
            end
          end
          pva_pkg::ACT_LOAD: begin
            finish = 1'b1;
            if (range_r) begin
              out_nxt.ok = 1'b1;
              // a fresh load starts at priority zero
              if (!ram_rdata[pva_pkg::PRIO_W]) begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, pva_pkg::PRIO_W'(0)};
              end
            end
          end
        endcase
      end

      ST_SCAN: begin
        idx_nxt = idx_r + CW'(1);
        if (take) begin
          pick_nxt       = vi;
          have_nxt       = 1'b1;
          best_stamp_nxt = stamp_r[vi];
        end
        if (cnt_hit) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if ((req_r.action == pva_pkg::ACT_UNLOAD) && match) begin
          valid_nxt[vi]   = 1'b0;
          playing_nxt[vi] = 1'b0;
          active_nxt      = active_r - CW'(1);
        end
        if (idx_r == CW'(VOICES - 1)) begin
          finish = 1'b1;
          unique case (req_r.action)
            pva_pkg::ACT_STOP: begin
              if (fin_have) begin
                do_stop           = 1'b1;
                out_nxt.ok        = 1'b1;
                out_nxt.voice_out = 4'(fin_pick);
              end
            end
            pva_pkg::ACT_NEWEST: begin
              if (fin_have) begin
                out_nxt.ok           = 1'b1;
                out_nxt.voice_out    = 4'(fin_pick);
                out_nxt.volume_atten = lvl_vol;
                out_nxt.pan_level    = lvl_pan;
              end
            end
            pva_pkg::ACT_COUNT: begin
              out_nxt.ok            = 1'b1;
              out_nxt.playing_count = 4'(cnt_r + CW'(cnt_hit));
            end
            pva_pkg::ACT_UNLOAD: begin
              out_nxt.ok = 1'b1;
              ram_we     = 1'b1;
              ram_wdata  = '0;
            end
            pva_pkg::ACT_PLAY: begin
              // restart the lowest voice of the same sound
              if (fin_have) begin
                do_restart        = 1'b1;
                out_nxt.ok        = 1'b1;
                out_nxt.voice_out = 4'(fin_pick);
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_STEAL: begin
        ram_raddr = vs_ext[SW-1:0];
        idx_nxt   = idx_r + CW'(1);
        if (take) begin
          pick_nxt      = ev_vi;
          have_nxt      = 1'b1;
          best_prio_nxt = ram_rdata[pva_pkg::PRIO_W-1:0];
        end
        if (idx_r == CW'(VOICES)) begin
          if (fin_have) begin
            do_start = 1'b1;
            st_repl  = 1'b1;
          end else if (req_r.allow_restart) begin
            state_nxt = ST_SCAN;
            idx_nxt   = '0;
            have_nxt  = 1'b0;
          end else begin
            finish = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // new voice start, possibly on top of a reclaimed or stolen voice
    if (do_start) begin
      finish               = 1'b1;
      valid_nxt[st_pick]   = 1'b1;
      playing_nxt[st_pick] = 1'b1;
      snd_we               = 1'b1;
      stamp_we             = 1'b1;
      voice_wi             = st_pick;
      ctr_nxt              = ctr_r + 32'd1;
      if (!st_repl) begin
        active_nxt = active_r + CW'(1);
      end
      out_nxt.ok           = 1'b1;
      out_nxt.voice_out    = 4'(st_pick);
      out_nxt.replaced     = st_repl;
      out_nxt.volume_atten = lvl_vol;
      out_nxt.pan_level    = lvl_pan;
    end

    // restart keeps the voice settings, only restamps it and marks it playing
    if (do_restart) begin
      playing_nxt[fin_pick] = 1'b1;
      stamp_we              = 1'b1;
      voice_wi              = fin_pick;
      ctr_nxt               = ctr_r + 32'd1;
    end

    if (do_stop) begin
      valid_nxt[fin_pick]   = 1'b0;
      playing_nxt[fin_pick] = 1'b0;
      active_nxt            = active_r - CW'(1);
    end

    if (finish) begin
      out_valid_nxt = 1'b1;
      state_nxt     = ST_IDLE;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      idx_r       <= '0;
      have_r      <= 1'b0;
      cnt_r       <= '0;
      valid_r     <= '0;
      playing_r   <= '0;
      active_r    <= '0;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      idx_r       <= idx_nxt;
      have_r      <= have_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      playing_r   <= playing_nxt;
      active_r    <= active_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: transaction capture, scan bests, voice entries, result
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_data;
      range_r <= in_range;
    end
    pick_r       <= pick_nxt;
    best_stamp_r <= best_stamp_nxt;
    best_prio_r  <= best_prio_nxt;
    if (snd_we) begin
      sound_r[voice_wi] <= req_r.sound_id;
    end
    if (stamp_we) begin
      stamp_r[voice_wi] <= ctr_r;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  // active count tracks the occupied voices
  a_active_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    32'(active_r) == $countones(valid_r))
    else $error("active voice count out of step with occupied voices");

  // result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a result leaves the block ready for the next transaction
  a_strobe_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // no result right after a transaction is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result strobe one cycle after accept");

  // a failed operation reports nothing else
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.ok) |-> (out_data.voice_out == 4'd0 &&
      !out_data.replaced && out_data.volume_atten == 12'sd0))
    else $error("failed operation with nonzero result fields");
`endif

endmodule

`default_nettype wire

// ===== sim/priority_voice_allocator_tb.sv =====
`timescale 1ns / 1ps

module priority_voice_allocator_tb;
  import pva_pkg::*;

  localparam int VOICES       = 12;
  localparam int SOUNDS       = 128;
  localparam int LIMIT_CYCLES = 400000;
  // slowest command is a steal that falls through to restart
  localparam int TAIL_CYCLES  = 2 * VOICES + 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;

  int fail_count = 0;
  int cycle_count = 0;

  // replies predicted for accepted commands, oldest first
  out_t voice_reply_q[$];

  // shadow of the allocator state
  logic        v_valid [VOICES];
  logic [6:0]  v_sound [VOICES];
  logic [31:0] v_stamp [VOICES];
  logic        v_live  [VOICES];
  int          n_active;
  logic [31:0] stamp_ctr;
  logic [7:0]  snd_prio   [SOUNDS];
  logic        snd_loaded [SOUNDS];

  // a few sounds that most traffic targets, so voices fill up and get stolen
  logic [6:0] sound_pool [6] = '{7'd0, 7'd1, 7'd42, 7'd85, 7'd126, 7'd127};

  priority_voice_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic void drop_voice(int v);
    v_valid[v] = 1'b0;
    v_live[v]  = 1'b0;
    if (n_active > 0) n_active--;
  endfunction

  function automatic out_t compute_voice_reply(in_t cmd);
    out_t r;
    int   i;
    int   pick;
    int   best;
    logic loaded;
    r      = '0;
    pick   = VOICES;
    loaded = snd_loaded[cmd.sound_id];
    case (cmd.action)
      ACT_PLAY: begin
        if (loaded) begin
          if (n_active >= VOICES) begin
            // reclaim a finished voice first
            for (i = 0; i < VOICES; i++)
              if (pick == VOICES && v_valid[i] && !v_live[i]) pick = i;
            // then steal the lowest priority strictly below the request
            if (pick == VOICES) begin
              best = cmd.priority_req;
              for (i = 0; i < VOICES; i++) begin
                if (v_valid[i] && snd_prio[v_sound[i]] < best) begin
                  best = snd_prio[v_sound[i]];
                  pick = i;
                end
              end
            end
            if (pick < VOICES) begin
              drop_voice(pick);
              r.replaced = 1'b1;
            end else if (cmd.allow_restart) begin
              // restart keeps the voice settings, levels stay zero
              for (i = 0; i < VOICES; i++) begin
                if (!r.ok && v_valid[i] && v_sound[i] == cmd.sound_id) begin
                  v_stamp[i]  = stamp_ctr;
                  stamp_ctr   = stamp_ctr + 1;
                  v_live[i]   = 1'b1;
                  r.ok        = 1'b1;
                  r.voice_out = 4'(i);
                end
              end
            end
          end else begin
            for (i = 0; i < VOICES; i++)
              if (pick == VOICES && !v_valid[i]) pick = i;
          end
          if (pick < VOICES) begin
            v_valid[pick] = 1'b1;
            v_sound[pick] = cmd.sound_id;
            v_stamp[pick] = stamp_ctr;
            v_live[pick]  = 1'b1;
            stamp_ctr     = stamp_ctr + 1;
            n_active++;
            r.ok           = 1'b1;
            r.voice_out    = 4'(pick);
            r.volume_atten = 12'((400 * (5 * int'(cmd.volume_in) - 635)) / 127);
            r.pan_level    = 12'((400 * (5 * int'(cmd.pan_in) - 315)) / 63);
          end
        end
      end
      ACT_STOP: begin
        if (loaded) begin
          for (i = 0; i < VOICES; i++)
            if (v_valid[i] && v_sound[i] == cmd.sound_id &&
                (pick == VOICES || v_stamp[i] < v_stamp[pick]))
              pick = i;
          if (pick < VOICES) begin
            drop_voice(pick);
            r.ok        = 1'b1;
            r.voice_out = 4'(pick);
          end
        end
      end
      ACT_SET_PRIO: begin
        if (loaded) begin
          snd_prio[cmd.sound_id] = cmd.priority_req;
          r.ok = 1'b1;
        end
      end
      ACT_FINISHED: begin
        if (cmd.voice_id < VOICES && v_valid[cmd.voice_id]) begin
          v_live[cmd.voice_id] = 1'b0;
          r.ok        = 1'b1;
          r.voice_out = cmd.voice_id;
        end
      end
      ACT_COUNT: begin
        if (loaded) begin
          for (i = 0; i < VOICES; i++)
            if (v_valid[i] && v_sound[i] == cmd.sound_id && v_live[i])
              r.playing_count = r.playing_count + 1'b1;
          r.ok = 1'b1;
        end
      end
      ACT_NEWEST: begin
        if (loaded) begin
          for (i = 0; i < VOICES; i++)
            if (v_valid[i] && v_sound[i] == cmd.sound_id &&
                (pick == VOICES || v_stamp[i] > v_stamp[pick]))
              pick = i;
          if (pick < VOICES) begin
            r.ok           = 1'b1;
            r.voice_out    = 4'(pick);
            r.volume_atten = 12'((400 * (5 * int'(cmd.volume_in) - 635)) / 127);
            r.pan_level    = 12'((400 * (5 * int'(cmd.pan_in) - 315)) / 63);
          end
        end
      end
      ACT_LOAD: begin
        if (!loaded) begin
          snd_loaded[cmd.sound_id] = 1'b1;
          snd_prio[cmd.sound_id]   = '0;
        end
        r.ok = 1'b1;
      end
      ACT_UNLOAD: begin
        if (loaded) begin
          for (i = 0; i < VOICES; i++)
            if (v_valid[i] && v_sound[i] == cmd.sound_id) drop_voice(i);
          snd_loaded[cmd.sound_id] = 1'b0;
          snd_prio[cmd.sound_id]   = '0;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_t cmd_of(action_t act, logic [6:0] snd, logic [7:0] prio,
                                 logic restart, logic [3:0] vid, logic [6:0] vol,
                                 logic [6:0] pan);
    in_t c;
    c.action        = act;
    c.sound_id      = snd;
    c.priority_req  = prio;
    c.allow_restart = restart;
    c.voice_id      = vid;
    c.volume_in     = vol;
    c.pan_in        = pan;
    return c;
  endfunction

  function automatic in_t random_cmd();
    in_t c;
    int  roll;
    if ($urandom_range(0, 9) == 0) c.sound_id = 7'($urandom_range(0, 127));
    else c.sound_id = sound_pool[$urandom_range(0, 5)];
    roll = $urandom_range(0, 99);
    if (roll < 25) c.priority_req = 8'd0;
    else if (roll < 35) c.priority_req = 8'd255;
    else c.priority_req = 8'($urandom_range(0, 255));
    c.allow_restart = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 7) == 0) c.voice_id = 4'($urandom_range(VOICES, 15));
    else c.voice_id = 4'($urandom_range(0, VOICES - 1));
    c.volume_in = 7'($urandom_range(0, 127));
    c.pan_in    = 7'($urandom_range(0, 127));
    roll = $urandom_range(0, 99);
    if (roll < 40) c.action = ACT_PLAY;
    else if (roll < 50) c.action = ACT_STOP;
    else if (roll < 58) c.action = ACT_SET_PRIO;
    else if (roll < 68) c.action = ACT_FINISHED;
    else if (roll < 76) c.action = ACT_COUNT;
    else if (roll < 84) c.action = ACT_NEWEST;
    else if (roll < 94) c.action = ACT_LOAD;
    else c.action = ACT_UNLOAD;
    return c;
  endfunction

  // called at a rising edge; returns at the edge that took the transaction,
  // leaving start high so a back-to-back transaction needs no second update
  task automatic send_cmd(input in_t cmd);
    in_data <= cmd;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    voice_reply_q.push_back(compute_voice_reply(cmd));
  endtask

  task automatic sender_gap(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_replies_drained();
    start <= 1'b0;
    do @(posedge clk); while (voice_reply_q.size() != 0);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : check_replies
    out_t want;
    if (rst_n && out_valid) begin
      if (voice_reply_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        fail_count++;
      end else begin
        want = voice_reply_q.pop_front();
        check_field("ok", want.ok, out_data.ok);
        check_field("voice_out", want.voice_out, out_data.voice_out);
        check_field("replaced", want.replaced, out_data.replaced);
        check_field("playing_count", want.playing_count, out_data.playing_count);
        check_field("volume_atten", want.volume_atten, out_data.volume_atten);
        check_field("pan_level", want.pan_level, out_data.pan_level);
      end
    end
  end

  // commands on a sound that was never loaded, and bad voice numbers
  task automatic test_unloaded_sound();
    send_cmd(cmd_of(ACT_PLAY, 7'd9, 8'd255, 1'b1, 4'd0, 7'd127, 7'd127));
    send_cmd(cmd_of(ACT_FINISHED, 7'd0, 8'd0, 1'b0, 4'd15, 7'd0, 7'd0));
    send_cmd(cmd_of(ACT_FINISHED, 7'd0, 8'd0, 1'b0, 4'd0, 7'd0, 7'd0));
  endtask

  // fresh load, repeated load, priority write on the top slot
  task automatic test_load_and_priority();
    send_cmd(cmd_of(ACT_LOAD, 7'd127, 8'd0, 1'b0, 4'd0, 7'd0, 7'd0));
    send_cmd(cmd_of(ACT_LOAD, 7'd0, 8'd0, 1'b0, 4'd0, 7'd0, 7'd0));
    send_cmd(cmd_of(ACT_LOAD, 7'd0, 8'd0, 1'b0, 4'd0, 7'd0, 7'd0));
    send_cmd(cmd_of(ACT_SET_PRIO, 7'd127, 8'd255, 1'b0, 4'd0, 7'd0, 7'd0));
  endtask

  // every voice in use, level mapping at its ends and centre
  task automatic test_fill_voices();
    int         i;
    logic [6:0] vol;
    logic [6:0] pan;
    for (i = 0; i < VOICES - 1; i++) begin
      case (i)
        0: begin vol = 7'd0;   pan = 7'd0;   end
        1: begin vol = 7'd127; pan = 7'd127; end
        2: begin vol = 7'd64;  pan = 7'd63;  end
        default: begin
          vol = 7'($urandom_range(0, 127));
          pan = 7'($urandom_range(0, 127));
        end
      endcase
      send_cmd(cmd_of(ACT_PLAY, 7'd0, 8'd0, 1'b0, 4'd0, vol, pan));
    end
    send_cmd(cmd_of(ACT_PLAY, 7'd127, 8'd255, 1'b0, 4'd0, 7'd100, 7'd20));
  endtask

  // full pool: restart, plain failure, steal, reclaim, then lookups
  task automatic test_full_pool();
    send_cmd(cmd_of(ACT_PLAY, 7'd0, 8'd0, 1'b1, 4'd0, 7'd5, 7'd5));
    send_cmd(cmd_of(ACT_PLAY, 7'd0, 8'd0, 1'b0, 4'd0, 7'd5, 7'd5));
    send_cmd(cmd_of(ACT_PLAY, 7'd0, 8'd200, 1'b0, 4'd0, 7'd90, 7'd30));
    send_cmd(cmd_of(ACT_FINISHED, 7'd0, 8'd0, 1'b0, 4'd4, 7'd0, 7'd0));
    send_cmd(cmd_of(ACT_PLAY, 7'd127, 8'd0, 1'b0, 4'd0, 7'd70, 7'd110));
    send_cmd(cmd_of(ACT_COUNT, 7'd0, 8'd0, 1'b0, 4'd0, 7'd0, 7'd0));
    send_cmd(cmd_of(ACT_NEWEST, 7'd0, 8'd0, 1'b0, 4'd0, 7'd33, 7'd99));
    send_cmd(cmd_of(ACT_STOP, 7'd0, 8'd0, 1'b0, 4'd0, 7'd0, 7'd0));
    send_cmd(cmd_of(ACT_UNLOAD, 7'd127, 8'd0, 1'b0, 4'd0, 7'd0, 7'd0));
  endtask

  // hold off until the allocator has answered everything in flight
  task automatic test_quiet_pause();
    wait_replies_drained();
  endtask

  // mixed traffic; gaps come in bursts, with gap-free stretches between
  task automatic test_random_traffic(input int n_items, input bit with_gaps);
    int k;
    bit gaps_on;
    gaps_on = 1'b0;
    for (k = 0; k < n_items; k++) begin
      if (k % 50 == 0) gaps_on = with_gaps && ($urandom_range(0, 2) != 0);
      send_cmd(random_cmd());
      if (gaps_on && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 10));
    end
  endtask

  initial begin
    n_active  = 0;
    stamp_ctr = '0;
    for (int i = 0; i < VOICES; i++) begin
      v_valid[i] = 1'b0;
      v_sound[i] = '0;
      v_stamp[i] = '0;
      v_live[i]  = 1'b0;
    end
    for (int s = 0; s < SOUNDS; s++) begin
      snd_prio[s]   = '0;
      snd_loaded[s] = 1'b0;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_unloaded_sound();
    test_load_and_priority();
    test_fill_voices();
    test_full_pool();
    test_quiet_pause();
    test_random_traffic(1800, 1'b1);
    test_quiet_pause();
    test_random_traffic(400, 1'b0);

    start <= 1'b0;
    while (voice_reply_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/pva_pkg.sv
hw/rtl/pva_ram.sv
hw/rtl/pva_level_map.sv
hw/rtl/pva_pick_unit.sv
hw/rtl/priority_voice_allocator.sv
sim/priority_voice_allocator_tb.sv
